FILE: hdl/mcat_pkg.sv
`default_nettype none
package mcat_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W = 3;
    localparam int USEC_TICK_COUNT = 12;
    localparam logic [31:0] MAX_REL_US = 32'hFFFF_FFFF / USEC_TICK_COUNT;

    localparam logic [2:0] REQ_WAKEUP   = 3'd0;
    localparam logic [2:0] REQ_OPEN     = 3'd1;
    localparam logic [2:0] REQ_ARM_ONCE = 3'd2;
    localparam logic [2:0] REQ_ARM_PER  = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;

    localparam logic [1:0] KIND_FIRE    = 2'd0;
    localparam logic [1:0] KIND_COMPARE = 2'd1;
    localparam logic [1:0] KIND_ELAPSED = 2'd2;

    localparam logic [1:0] CFG_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_MIN_ONCE = 2'd1;
    localparam logic [1:0] CFG_MIN_PER  = 2'd2;

    // one memory word per channel: alarm time, period, open time, armed flag
    localparam int ENTRY_W = 64 * 3 + 1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  channel;
        logic [31:0] counter_sample;
        logic [63:0] delay_us;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  fired_channel;
        logic [31:0] compare_value;
        logic [63:0] elapsed_time;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [63:0] alarm_at;
        logic [63:0] period;
        logic [63:0] opened_at;
        logic        armed;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SINGLE_RD,
        ST_SINGLE_EV,
        ST_FIRE_OUT,
        ST_MIN_RD,
        ST_MIN_EV,
        ST_WIN_RD,
        ST_WIN_EV,
        ST_CMP_MUL,
        ST_CMP_OUT,
        ST_ELAPSED_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/mcat_ram.sv
`default_nettype none
module mcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/multi_channel_alarm_timer.sv
`default_nettype none
// Results: a read gives an elapsed result, an arm a compare result, an arm periodic
// with a nonzero period first a fire result for its channel, a wakeup a fire result
// per fired channel and then a compare result; an open gives none.
// Throughput: one item at a time; wakeups and arms walk the eight channel entries
// through one read port (fire pass for a wakeup, soonest pass, window pass), and
// output stalls lengthen the run of an item.
// Reset: time, prior sample, configuration and control registers go to reset values; the channel
// memory is not cleared, a valid bit per channel makes unwritten entries zero.
module multi_channel_alarm_timer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mcat_pkg::in_item_t in_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output mcat_pkg::out_item_t     out_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [19:0]        cfg_data
);
    import mcat_pkg::*;

    state_t state_reg, state_next;

    logic [15:0] window_reg;
    logic [15:0] min_once_reg;
    logic [19:0] min_per_reg;

    logic [63:0] now_reg, now_next;
    logic [31:0] prior_reg, prior_next;
    in_item_t    item_reg;
    logic [31:0] diff_reg, diff_next;
    logic [32:0] quo_reg, quo_next;   // ceil quotient via multiply by reciprocal

    logic [CH_W-1:0] idx_reg, idx_next;
    logic [NUM_CHANNELS-1:0] valid_reg, valid_next;

    logic        found_reg, found_next;
    logic [63:0] best_reg, best_next;
    logic [63:0] wend_reg, wend_next;
    logic [31:0] rel_reg, rel_next;
    logic        fire_last_reg, fire_last_next;  // set when the fire output ends the fire scan
    logic [CH_W-1:0] fire_ch_reg, fire_ch_next;  // channel of the pending fire item
    logic [63:0] span_reg, span_next;            // elapsed answer held for output

    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    // memory port
    logic            mem_we;
    logic [CH_W-1:0] mem_waddr, mem_raddr;
    entry_t          mem_wdata, mem_rdata_raw, ent;

    mcat_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CHANNELS)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    logic [CH_W-1:0] rd_idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_idx_reg <= '0;
        else
            rd_idx_reg <= mem_raddr;
    end
    // entries never written read as zero
    assign ent = valid_reg[rd_idx_reg] ? mem_rdata_raw : '0;

    wire in_acc  = in_valid && !in_stall;
    wire out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // divide by 12: q = (d*0xAAAAAAAB)>>35, then fix up to ceiling
    logic [63:0] div_prod;
    logic [31:0] q_fl;
    assign div_prod = 64'(diff_reg) * 64'(32'hAAAA_AAAB);
    assign q_fl     = {3'b000, div_prod[63:35]};

    logic [63:0] ch_delay_once, ch_period;
    assign ch_delay_once = (item_reg.delay_us < 64'(min_once_reg)) ?
                           64'(min_once_reg) : item_reg.delay_us;
    assign ch_period     = (item_reg.delay_us < 64'(min_per_reg)) ?
                           64'(min_per_reg) : item_reg.delay_us;

    logic [63:0] wsum;
    logic        wcarry;
    assign {wcarry, wsum} = 65'(best_reg) + 65'(window_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= 16'd250;
            min_once_reg  <= 16'd250;
            min_per_reg   <= 20'd1000;
            now_reg       <= '0;
            prior_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            prior_reg     <= prior_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW:   window_reg   <= cfg_data[15:0];
                    CFG_MIN_ONCE: min_once_reg <= cfg_data[15:0];
                    CFG_MIN_PER:  min_per_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= in_data;
        diff_reg      <= diff_next;
        quo_reg       <= quo_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        wend_reg      <= wend_next;
        rel_reg       <= rel_next;
        fire_last_reg <= fire_last_next;
        fire_ch_reg   <= fire_ch_next;
        span_reg      <= span_next;
        out_reg       <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc && in_data.req_type <= REQ_READ)
                    state_next = ST_DIV;
            ST_DIV:      state_next = ST_DISPATCH;
            ST_DISPATCH:
                case (item_reg.req_type)
                    REQ_WAKEUP: state_next = ST_SCAN_RD;
                    REQ_OPEN:   state_next = ST_SINGLE_RD;
                    REQ_ARM_ONCE, REQ_ARM_PER, REQ_READ: state_next = ST_SINGLE_RD;
                    default:    state_next = ST_IDLE;
                endcase
            ST_SCAN_RD:   state_next = ST_SCAN_EV;
            ST_SCAN_EV:
                if (valid_reg[idx_reg] && ent.armed && ent.alarm_at <= now_reg)
                    state_next = ST_FIRE_OUT;
                else if (idx_reg == CH_W'(NUM_CHANNELS - 1))
                    state_next = ST_MIN_RD;
                else
                    state_next = ST_SCAN_RD;
            ST_SINGLE_RD: state_next = ST_SINGLE_EV;
            ST_SINGLE_EV:
                case (item_reg.req_type)
                    REQ_OPEN:     state_next = ST_IDLE;
                    REQ_READ:     state_next = ST_ELAPSED_OUT;
                    REQ_ARM_PER:  state_next = (item_reg.delay_us != 0) ? ST_FIRE_OUT
                                                                         : ST_MIN_RD;
                    default:      state_next = ST_MIN_RD;
                endcase
            ST_FIRE_OUT:
                if (out_free)
                    state_next = fire_last_reg ? ST_MIN_RD : ST_SCAN_RD;
            ST_MIN_RD:    state_next = ST_MIN_EV;
            ST_MIN_EV:
                state_next = (idx_reg == CH_W'(NUM_CHANNELS - 1)) ? ST_WIN_RD : ST_MIN_RD;
            ST_WIN_RD:    state_next = ST_WIN_EV;
            ST_WIN_EV:
                state_next = (idx_reg == CH_W'(NUM_CHANNELS - 1)) ? ST_CMP_MUL : ST_WIN_RD;
            ST_CMP_MUL:   state_next = ST_CMP_OUT;
            ST_CMP_OUT:     if (out_free) state_next = ST_IDLE;
            ST_ELAPSED_OUT: if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs; the output register is loaded only when it is free
    always_comb
    begin
        now_next       = now_reg;
        prior_next     = prior_reg;
        diff_next      = diff_reg;
        quo_next       = quo_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        wend_next      = wend_reg;
        rel_next       = rel_reg;
        fire_last_next = fire_last_reg;
        fire_ch_next   = fire_ch_reg;
        span_next      = span_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = ent;
        mem_raddr      = idx_reg;

        case (state_reg)
            ST_IDLE:
                // unknown requests leave time and the prior sample alone
                if (in_acc && in_data.req_type <= REQ_READ)
                begin
                    diff_next  = in_data.counter_sample - prior_reg;
                    prior_next = in_data.counter_sample;
                end
            ST_DIV:
            begin
                // floor, then step up when a remainder is left
                quo_next = 33'(q_fl) +
                           33'((q_fl * 32'(USEC_TICK_COUNT)) != diff_reg);
            end
            ST_DISPATCH:
            begin
                now_next = now_reg + 64'(quo_reg);
                idx_next = (item_reg.req_type == REQ_WAKEUP) ? '0 : item_reg.channel;
            end
            ST_SCAN_RD: ;
            ST_SCAN_EV:
                if (valid_reg[idx_reg] && ent.armed && ent.alarm_at <= now_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = ent;
                    if (ent.period != 0)
                        mem_wdata.alarm_at = ent.alarm_at + ent.period;
                    else
                        mem_wdata.armed = 1'b0;
                    fire_ch_next   = idx_reg;
                    fire_last_next = (idx_reg == CH_W'(NUM_CHANNELS - 1));
                    if (idx_reg == CH_W'(NUM_CHANNELS - 1))
                        idx_next = '0;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    idx_next = (idx_reg == CH_W'(NUM_CHANNELS - 1)) ? '0 : idx_reg + 1'b1;
                end
            ST_SINGLE_RD: ;
            ST_SINGLE_EV:
            begin
                mem_we = 1'b1;
                valid_next[idx_reg] = 1'b1;
                mem_wdata = ent;
                case (item_reg.req_type)
                    REQ_OPEN:
                    begin
                        mem_wdata.opened_at = now_reg;
                        mem_wdata.armed     = 1'b0;
                        mem_wdata.period    = '0;
                    end
                    REQ_ARM_ONCE:
                    begin
                        mem_wdata.period   = '0;
                        mem_wdata.alarm_at = now_reg + ch_delay_once;
                        mem_wdata.armed    = 1'b1;
                    end
                    REQ_ARM_PER:
                    begin
                        mem_wdata.period = '0;
                        mem_wdata.armed  = 1'b0;
                        if (item_reg.delay_us != 0)
                        begin
                            mem_wdata.period   = ch_period;
                            mem_wdata.alarm_at = now_reg + ch_period;
                            mem_wdata.armed    = 1'b1;
                        end
                        fire_ch_next   = item_reg.channel;
                        fire_last_next = 1'b1;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                        valid_next = valid_reg;
                        span_next  = now_reg - ent.opened_at;
                    end
                endcase
                idx_next   = '0;
                found_next = 1'b0;
            end
            ST_FIRE_OUT:
                if (out_free)
                begin
                    out_next.result_kind   = KIND_FIRE;
                    out_next.fired_channel = fire_ch_reg;
                    out_next.compare_value = '0;
                    out_next.elapsed_time  = '0;
                    out_next.last_of_run   = 1'b0;
                    out_valid_next = 1'b1;
                    if (fire_last_reg)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                    end
                end
            ST_MIN_RD:
                if (idx_reg == '0)
                    found_next = 1'b0;
            ST_MIN_EV:
            begin
                if (ent.armed && (!found_reg || ent.alarm_at < best_reg))
                begin
                    best_next  = ent.alarm_at;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_WIN_RD:
                if (idx_reg == '0)
                begin
                    wend_next = wcarry ? '1 : wsum;
                    if (!found_reg)
                        best_next = '1;
                end
            ST_WIN_EV:
            begin
                if (found_reg && ent.armed && ent.alarm_at <= wend_reg &&
                    ent.alarm_at > best_reg)
                    best_next = ent.alarm_at;
                idx_next = idx_reg + 1'b1;
            end
            ST_CMP_MUL:
            begin
                if (best_reg > now_reg)
                    rel_next = ((best_reg - now_reg) > 64'(MAX_REL_US)) ? MAX_REL_US
                               : 32'(best_reg - now_reg);
                else
                    rel_next = 32'd1;
            end
            ST_CMP_OUT:
                if (out_free)
                begin
                    out_next.result_kind   = KIND_COMPARE;
                    out_next.fired_channel = '0;
                    out_next.compare_value = 32'(36'(rel_reg) * 36'(USEC_TICK_COUNT))
                                             + prior_reg;
                    out_next.elapsed_time  = '0;
                    out_next.last_of_run   = 1'b1;
                    out_valid_next = 1'b1;
                end
            ST_ELAPSED_OUT:
                if (out_free)
                begin
                    out_next.result_kind   = KIND_ELAPSED;
                    out_next.fired_channel = item_reg.channel;
                    out_next.compare_value = '0;
                    out_next.elapsed_time  = span_reg;
                    out_next.last_of_run   = 1'b1;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    // a fire output carries kind fire and is not last of its run; wakeup fires come in channel order
    property p_fire_kind;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRE_OUT && out_free) |=> (out_valid && out_data.result_kind == KIND_FIRE
                                                    && !out_data.last_of_run);
    endproperty
    a_fire_kind: assert property (p_fire_kind) else $error("fire result malformed");

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall) else $error("input taken while busy");

    a_cmp_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP_OUT && out_free) |=> out_data.last_of_run)
        else $error("compare not last");

endmodule
`default_nettype wire
